// ===== design/qdt_pkg.sv =====
`timescale 1ns / 1ps

package qdt_pkg;

    // Special byte codes
    localparam logic [7:0] QUOTE_BYTE   = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIMITER_SET   = 2'd0,
        REG_DELIMITER_COUNT = 2'd1,
        REG_TRIM_NEWLINE    = 2'd2
    } cfg_reg_t;

    localparam int CFG_DATA_W  = 64;
    localparam int DELIM_CNT_W = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One result item
    typedef struct packed {
        logic       has_byte;
        logic [7:0] token_byte;
        logic       token_end;
        logic       string_end;
    } qdt_result_t;

endpackage

// ===== design/qdt_front.sv =====
`timescale 1ns / 1ps

module qdt_front #(
    parameter int MAX_DELIMITERS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    input  logic [qdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qdt_pkg::CFG_DATA_W-1:0] cfg_data,
    // input bytes
    input  logic                          in_valid,
    input  logic [7:0]                    in_char,
    input  logic                          in_last,
    input  logic                          queue_full,
    output logic                          in_ready,
    // classified results toward the queue
    output logic                          push,
    output qdt_pkg::qdt_result_t          push_data
);
    import qdt_pkg::*;

    logic [MAX_DELIMITERS-1:0][7:0] delim_reg;
    logic [DELIM_CNT_W-1:0]         delim_cnt_reg;
    logic                           trim_reg;

    logic inside_quotes_reg, inside_quotes_next;
    logic after_delim_reg, after_delim_next;
    logic seen_any_reg, seen_any_next;

    logic [MAX_DELIMITERS-1:0] lane_hit;
    logic                      is_delim;
    logic                      accept;
    qdt_result_t               res;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg     <= (MAX_DELIMITERS*8)'(NEWLINE_BYTE);
            delim_cnt_reg <= DELIM_CNT_W'(1);
            trim_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DELIMITER_SET:   delim_reg     <= cfg_data[MAX_DELIMITERS*8-1:0];
                REG_DELIMITER_COUNT: delim_cnt_reg <= cfg_data[DELIM_CNT_W-1:0];
                REG_TRIM_NEWLINE:    trim_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Compare against every active delimiter lane in parallel
    always_comb begin
        for (int k = 0; k < MAX_DELIMITERS; k++) begin
            lane_hit[k] = (delim_cnt_reg > DELIM_CNT_W'(k)) && (delim_reg[k] == in_char);
        end
    end
    assign is_delim = |lane_hit;

    // Classify the byte and form its result
    always_comb begin
        res                = '0;
        res.string_end     = in_last;
        inside_quotes_next = inside_quotes_reg;
        after_delim_next   = after_delim_reg;
        if (in_last && trim_reg && in_char == NEWLINE_BYTE) begin
            res.token_end = seen_any_reg && !after_delim_reg;
        end else if (in_char == QUOTE_BYTE) begin
            inside_quotes_next = !inside_quotes_reg;
            after_delim_next   = 1'b0;
            res.token_end      = in_last;
        end else if (!inside_quotes_reg && is_delim) begin
            res.token_end    = 1'b1;
            after_delim_next = 1'b1;
        end else begin
            res.has_byte     = 1'b1;
            res.token_byte   = in_char;
            after_delim_next = 1'b0;
            res.token_end    = in_last;
        end
        seen_any_next = 1'b1;
        // Clear string state after the final byte
        if (in_last) begin
            inside_quotes_next = 1'b0;
            after_delim_next   = 1'b0;
            seen_any_next      = 1'b0;
        end
    end

    // Drop quote bytes unless they end the string
    assign push      = accept && (in_last || res.has_byte || res.token_end);
    assign push_data = res;

    // Advance string state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_quotes_reg <= 1'b0;
            after_delim_reg   <= 1'b0;
            seen_any_reg      <= 1'b0;
        end else if (accept) begin
            inside_quotes_reg <= inside_quotes_next;
            after_delim_reg   <= after_delim_next;
            seen_any_reg      <= seen_any_next;
        end
    end

endmodule

// ===== design/qdt_queue.sv =====
`timescale 1ns / 1ps

module qdt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  qdt_pkg::qdt_result_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output qdt_pkg::qdt_result_t pop_data
);
    import qdt_pkg::*;

    qdt_result_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Move pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/qdt_back.sv =====
`timescale 1ns / 1ps

module qdt_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  qdt_pkg::qdt_result_t q_data,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);
    import qdt_pkg::*;

    qdt_result_t out_reg;
    logic        valid_reg;
    logic        load;

    // Refill the output register when it is empty or being taken
    assign load  = !valid_reg || m_tready;
    assign q_pop = load && q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg.token_byte;
    assign m_tuser  = {out_reg.token_end, out_reg.has_byte};
    assign m_tlast  = out_reg.string_end;

endmodule

// ===== design/quoted_delimiter_tokenizer.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports                               | Content
// s_      | in        | s_tvalid s_tready s_tdata s_tlast   | char_in, last_char
// m_      | out       | m_tvalid m_tready m_tdata m_tuser   | has_byte, token_byte,
//         |           | m_tlast                             | token_end, string_end
// cfg_    | in        | cfg_valid cfg_ready cfg_index       | register writes
//         |           | cfg_data                            |
//
// One byte per cycle while s_tready is high; a result passes through the queue and then the output register to m_.
// Delimiter compares run in parallel lanes, one per MAX_DELIMITERS.
// A two-entry queue and an output register part input from output; s_tready
// falls only when the queue is full. Configuration writes are never stalled.
// aresetn is synchronous, active low, and restores register defaults.

module quoted_delimiter_tokenizer #(
    parameter int MAX_DELIMITERS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_in
    input  logic                          s_tlast,   // last_char
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] token_byte
    output logic [1:0]                    m_tuser,   // [0] has_byte, [1] token_end
    output logic                          m_tlast,   // string_end
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qdt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import qdt_pkg::*;

    logic        push, full, pop, not_empty;
    qdt_result_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    qdt_front #(
        .MAX_DELIMITERS(MAX_DELIMITERS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .queue_full(full),
        .in_ready  (s_tready),
        .push      (push),
        .push_data (push_data)
    );

    qdt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .not_empty(not_empty),
        .pop_data (pop_data)
    );

    qdt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(not_empty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== design/qdt_checker.sv =====
`timescale 1ns / 1ps

module qdt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import qdt_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Quotes are always stripped from tokens
    a_no_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata != QUOTE_BYTE)
        else $error("quote emitted as token byte");

    // A result without a byte carries a zero byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("token_byte nonzero without has_byte");

    // Only the final result of a string may be empty
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0] || m_tuser[1])
        else $error("empty result before string end");

endmodule

bind quoted_delimiter_tokenizer qdt_checker u_qdt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
